>>> rtl/centered_window_average_assert.svh
// Assertion macros used by the port checker of the centered window average.
// No dependencies; the using module must have clk and rst_n in scope.
`ifndef CENTERED_WINDOW_AVERAGE_ASSERT_SVH
`define CENTERED_WINDOW_AVERAGE_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define CWA_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("centered_window_average: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define CWA_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("centered_window_average: next-cycle check failed");

`endif

>>> rtl/cwa_pkg.sv
// Shared types and constants of the centered window average.
// No dependencies; used by all RTL and checker files.
package cwa_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int AVG_W     = 17;
    localparam int RADIUS_W  = 5;
    localparam int DIVISOR_W = RADIUS_W + 1;

    // Average given where the window does not fit in the stream
    localparam logic signed [AVG_W-1:0] NO_FIT = '1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                is_last;
    } cwa_in_t;

    typedef struct packed {
        logic signed [AVG_W-1:0] average;
        logic                    last_of_run;
    } cwa_out_t;

endpackage

>>> rtl/centered_window_average.sv
// Centered moving average over a sample stream: top level.
// Depends on cwa_pkg and cwa_divider.
//
// Usage:
//   src channel (src_valid/src_stall/src_data) carries one sample and its
//   end-of-stream mark per transaction. res channel (res_valid/res_stall/
//   res_data) carries the averages in index order, -1 where the window of
//   2k+1 samples does not fit, last_of_run on the final result of a stream.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes the radius k; a write
//   also restarts the stream. Writes are taken only while the block is idle.
// Timing:
//   One sample at a time. A sample whose window fits holds the input
//   while the bit-serial divider works out its average; other samples go
//   from the sum state straight to their results or back to idle.
//   Each result passes through the output register. The ring is
//   read and written in the accept cycle; the window sum in the cycle after.
// Reset: radius zero, empty stream, no result pending; ring contents are
//   unknown but never read before being written within a stream.
// Backpressure: while res_stall is high the output register holds its result
//   and src_stall stays high until the sample's last result is loaded.
module centered_window_average #(
    parameter int MAX_RADIUS  = 31,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          src_valid,
    output logic                          src_stall,
    input  cwa_pkg::cwa_in_t              src_data,
    output logic                          res_valid,
    input  logic                          res_stall,
    output cwa_pkg::cwa_out_t             res_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cwa_pkg::RADIUS_W-1:0]  cfg_data
);

    localparam int SW         = cwa_pkg::SAMPLE_W;
    localparam int RW         = cwa_pkg::RADIUS_W;
    localparam int AW         = cwa_pkg::AVG_W;
    localparam int RADIUS_CAP = (1 << RW) - 1;
    localparam int K_MAX      = (MAX_RADIUS < RADIUS_CAP) ? MAX_RADIUS : RADIUS_CAP;
    localparam int DEPTH      = 2 * MAX_RADIUS + 1;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int PTRX_W     = PTR_W + 1;
    localparam int SPAN_W     = $clog2(2 * K_MAX + 1);
    localparam int EFF_SB     = (SAMPLE_BITS < SW) ? SAMPLE_BITS : SW;
    localparam int SUM_W      = EFF_SB + $clog2(2 * K_MAX + 2);
    localparam int RES_W      = $clog2(K_MAX + 2);
    localparam logic [SW-1:0] SAMPLE_MASK = SW'((33'(1) << EFF_SB) - 33'd1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SUM  = 4'b0010,
        S_DIV  = 4'b0100,
        S_EMIT = 4'b1000
    } cwa_state_t;

    cwa_state_t         state_reg, state_next;
    logic [RW-1:0]      radius_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [SPAN_W-1:0]  seen_reg;
    logic [PTR_W-1:0]   ptr_reg;

    logic [SW-1:0]      ring [DEPTH];
    logic [SW-1:0]      rd_reg;

    logic [SW-1:0]      s_reg;
    logic               last_reg;
    logic [SUM_W-1:0]   full_reg;
    logic               fits_reg;
    logic               zero_span_reg;
    logic               use_quot_reg;
    logic [RES_W-1:0]   res_cnt_reg;

    logic               res_valid_reg;
    cwa_pkg::cwa_out_t  res_data_reg;

    logic [RW-1:0]      k_w;
    logic [SPAN_W-1:0]  k_s;
    logic [SPAN_W-1:0]  span_w;
    logic [SW-1:0]      s_w;
    logic [SUM_W-1:0]   full_w;
    logic               has_avg;
    logic               fits;
    logic [SPAN_W:0]    c1;
    logic [RES_W-1:0]   trail;
    logic [RES_W-1:0]   total;
    logic [PTR_W-1:0]   span_p;
    logic [PTR_W-1:0]   old_idx;
    logic [PTR_W-1:0]   ptr_inc;
    logic [SW-1:0]      sub_w;
    logic               accept;
    logic               cfg_write;
    logic               emit;
    logic               div_start;
    logic               div_done;
    logic [SUM_W-1:0]   div_quot;

    // Effective radius and per-sample decisions
    always_comb
    begin
        k_w     = (32'(radius_reg) > K_MAX) ? RW'(K_MAX) : radius_reg;
        k_s     = SPAN_W'(k_w);
        span_w  = SPAN_W'({k_w, 1'b0});
        s_w     = src_data.sample & SAMPLE_MASK;
        full_w  = sum_reg + SUM_W'(s_w);
        has_avg = seen_reg >= k_s;
        fits    = seen_reg >= span_w;
        c1      = {1'b0, seen_reg} + (SPAN_W+1)'(1);
        trail   = (c1 < {1'b0, k_s}) ? RES_W'(c1) : RES_W'(k_s);
        total   = RES_W'(has_avg) + (src_data.is_last ? trail : RES_W'(0));
        span_p  = PTR_W'(span_w);
        old_idx = (ptr_reg >= span_p) ? PTR_W'(ptr_reg - span_p)
                : PTR_W'(PTRX_W'(ptr_reg) + PTRX_W'(DEPTH) - PTRX_W'(span_p));
        ptr_inc = (ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : ptr_reg + PTR_W'(1);
        sub_w   = zero_span_reg ? s_reg : rd_reg;
    end

    // Handshakes
    assign src_stall = (state_reg != S_IDLE) || cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign accept    = src_valid && !src_stall;
    assign cfg_write = cfg_valid && cfg_ready;
    assign emit      = (state_reg == S_EMIT) && (!res_valid_reg || !res_stall);
    assign div_start = (state_reg == S_SUM) && use_quot_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (use_quot_reg)
                begin
                    state_next = S_DIV;
                end
                else if (res_cnt_reg != '0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit && (res_cnt_reg == RES_W'(1)))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state: radius, stream counters, sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            radius_reg    <= '0;
            sum_reg       <= '0;
            seen_reg      <= '0;
            ptr_reg       <= '0;
            use_quot_reg  <= 1'b0;
            res_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Register write restarts the stream
            if (cfg_write)
            begin
                radius_reg <= cfg_data;
                sum_reg    <= '0;
                seen_reg   <= '0;
                ptr_reg    <= '0;
            end

            // Advance the counters on an accepted sample
            if (accept)
            begin
                use_quot_reg <= has_avg && fits;
                res_cnt_reg  <= total;
                if (src_data.is_last)
                begin
                    seen_reg <= '0;
                    ptr_reg  <= '0;
                end
                else
                begin
                    ptr_reg <= ptr_inc;
                    if (!fits)
                    begin
                        seen_reg <= seen_reg + SPAN_W'(1);
                    end
                end
            end

            // Update the window sum once the ring data is back: clear, slide or grow
            if (state_reg == S_SUM)
            begin
                if (last_reg)
                begin
                    sum_reg <= '0;
                end
                else if (fits_reg)
                begin
                    sum_reg <= full_reg - SUM_W'(sub_w);
                end
                else
                begin
                    sum_reg <= full_reg;
                end
            end

            // Count results out; hold the output while stalled
            if (emit)
            begin
                use_quot_reg  <= 1'b0;
                res_cnt_reg   <= res_cnt_reg - RES_W'(1);
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Per-sample payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_reg         <= s_w;
            last_reg      <= src_data.is_last;
            full_reg      <= full_w;
            fits_reg      <= fits;
            zero_span_reg <= (span_w == '0);
        end
    end

    // Ring memory: write the new sample, read the one leaving the window
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ring[ptr_reg] <= s_w;
            rd_reg        <= ring[old_idx];
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_data_reg.average     <= use_quot_reg ? AW'(div_quot) : cwa_pkg::NO_FIT;
            res_data_reg.last_of_run <= last_reg && (res_cnt_reg == RES_W'(1));
        end
    end

    cwa_divider #(
        .DIVIDEND_W (SUM_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (full_reg),
        .divisor  ({k_w, 1'b1}),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

>>> rtl/cwa_divider.sv
// Restoring divider, one quotient bit per cycle, for the window average.
// Depends on cwa_pkg for the divisor width.
module cwa_divider #(
    parameter int DIVIDEND_W = 22
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [DIVIDEND_W-1:0]          dividend,
    input  logic [cwa_pkg::DIVISOR_W-1:0]  divisor,
    output logic                           done,
    output logic [DIVIDEND_W-1:0]          quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);
    localparam int DW     = cwa_pkg::DIVISOR_W;

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DW-1:0]         rem_reg;
    logic [DW-1:0]         div_reg;
    logic [DW:0]           trial;
    logic                  ge;
    logic [DW-1:0]         rem_next;
    logic                  last_step;

    // Shift the next dividend bit into the remainder and try to subtract
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
        ge        = trial >= {1'b0, div_reg};
        rem_next  = ge ? DW'(trial - {1'b0, div_reg}) : DW'(trial);
        last_step = step_reg == STEP_W'(DIVIDEND_W - 1);
    end

    // Control: step count and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: dividend shifts out as quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/cwa_checker.sv
// Port-level checks of the centered window average, bound to the top level.
// Depends on cwa_pkg and centered_window_average_assert.svh.
`include "centered_window_average_assert.svh"

module cwa_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          src_valid,
    input logic                          src_stall,
    input cwa_pkg::cwa_in_t              src_data,
    input logic                          res_valid,
    input logic                          res_stall,
    input cwa_pkg::cwa_out_t             res_data,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [cwa_pkg::RADIUS_W-1:0]  cfg_data
);

    // Hold a stalled result transaction
    `CWA_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_data))

    // Never take a sample and a register write on the same edge
    `CWA_ASSERT_NOW(a_cfg_excl, cfg_valid && cfg_ready, src_stall)

    // One sample at a time: stall right after an accepted sample
    `CWA_ASSERT_NEXT(a_src_busy, src_valid && !src_stall, src_stall)

    // No register write while a sample is in flight
    `CWA_ASSERT_NEXT(a_cfg_busy, src_valid && !src_stall, !cfg_ready)

endmodule

bind centered_window_average cwa_checker u_cwa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
);

>>> verif/cwa_window_checker.sv
// Checker for the centered window average: watches the src, res and cfg channels,
// predicts the averages owed for each sample and compares them with the results.
// Depends on cwa_pkg.
module cwa_window_checker
    import cwa_pkg::*;
#(
    parameter int MAX_RADIUS = 31
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    input  logic                src_stall,
    input  cwa_in_t             src_data,
    input  logic                res_valid,
    input  logic                res_stall,
    input  cwa_out_t            res_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [RADIUS_W-1:0] cfg_data,
    output int                  mismatches,
    output int                  owed_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH  = 2 * MAX_RADIUS + 1;

    // Own copy of the window state
    logic [SAMPLE_W-1:0] history [RING_DEPTH];
    logic [31:0]         win_sum;
    int unsigned         seen;
    int unsigned         wr_slot;
    logic [RADIUS_W-1:0] radius;

    // Averages owed by the block, oldest first
    cwa_out_t owed_avgs[$];

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Restart the stream: empty window, ring written from slot zero
    task automatic restart_window();
        win_sum = '0;
        seen    = 0;
        wr_slot = 0;
    endtask

    // Work out the averages caused by one sample transaction
    task automatic predict_averages(input cwa_in_t item);
        int unsigned k;
        int unsigned span;
        int unsigned c;
        int unsigned trail;
        int unsigned old_slot;
        logic [31:0] full;
        cwa_out_t    res;
        k    = (radius > MAX_RADIUS) ? MAX_RADIUS : radius;
        span = 2 * k;
        c    = seen;
        full = win_sum + item.sample;
        history[wr_slot] = item.sample;
        trail = 0;
        if (item.is_last)
            trail = (c + 1 < k) ? c + 1 : k;

        // Result for the index k samples back
        if (c >= k)
        begin
            if (c >= span)
                res.average = AVG_W'(full / (span + 1));
            else
                res.average = NO_FIT;
            res.last_of_run = item.is_last && (trail == 0);
            owed_avgs.push_back(res);
        end

        // Slide the window once it is full, else grow it
        if (c >= span)
        begin
            old_slot = (wr_slot + RING_DEPTH - span) % RING_DEPTH;
            win_sum  = full - history[old_slot];
        end
        else
        begin
            win_sum = full;
            seen    = c + 1;
        end
        if (seen > span)
            seen = span;
        wr_slot = (wr_slot + 1) % RING_DEPTH;

        // Flush the trailing indexes at the end of the stream
        if (item.is_last)
        begin
            for (int t = 0; t < trail; t++)
            begin
                res.average     = NO_FIT;
                res.last_of_run = (t == trail - 1);
                owed_avgs.push_back(res);
            end
            restart_window();
        end
    endtask

    // Compare one result transaction with the oldest owed average
    task automatic check_result(input cwa_out_t got);
        cwa_out_t want;
        if (owed_avgs.size() == 0)
        begin
            report_mismatch($sformatf("result average=%0d last=%0b with nothing owed",
                got.average, got.last_of_run));
        end
        else
        begin
            want = owed_avgs.pop_front();
            if (got.average !== want.average)
                report_mismatch($sformatf("average %0d, expected %0d",
                    got.average, want.average));
            if (got.last_of_run !== want.last_of_run)
                report_mismatch($sformatf("last_of_run %0b, expected %0b",
                    got.last_of_run, want.last_of_run));
        end
    endtask

    // Track every accepted transaction on the three channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_avgs.delete();
            radius = '0;
            restart_window();
            owed_count = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
                check_result(res_data);
            if (cfg_valid && cfg_ready)
            begin
                radius = cfg_data;
                restart_window();
            end
            if (src_valid && !src_stall)
                predict_averages(src_data);
            owed_count = owed_avgs.size();
        end
    end

endmodule

>>> verif/centered_window_average_tb.sv
// Testbench top for the centered window average: drives samples and radius writes,
// stalls the result side, and gives the verdict from the checker's mismatch count.
// Depends on cwa_pkg, centered_window_average and cwa_window_checker.
module centered_window_average_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cwa_pkg::*;

    localparam int MAX_RADIUS    = 31;
    localparam int TARGET_ITEMS  = 350;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 200;
    localparam int IDLE_LIMIT    = 4000;

    localparam int STYLE_RANDOM  = 0;
    localparam int STYLE_MAX     = 1;
    localparam int STYLE_ZERO    = 2;
    localparam int STYLE_PATTERN = 3;

    logic                clk;
    logic                rst_n;
    logic                src_valid;
    logic                src_stall;
    cwa_in_t             src_data;
    logic                res_valid;
    logic                res_stall;
    cwa_out_t            res_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [RADIUS_W-1:0] cfg_data;

    int   mismatches;
    int   owed_count;
    int   items_sent;
    int   burst_left;
    int   idle_cycles;
    logic hold_req;

    centered_window_average #(
        .MAX_RADIUS (MAX_RADIUS),
        .SAMPLE_BITS(SAMPLE_W)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .src_valid(src_valid),
        .src_stall(src_stall),
        .src_data (src_data),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_data (res_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    cwa_window_checker #(
        .MAX_RADIUS(MAX_RADIUS)
    ) window_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .mismatches(mismatches),
        .owed_count(owed_count)
    );

    // Free-running clock, 2 ns period
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Pick one sample value in the given style
    function automatic logic [SAMPLE_W-1:0] pick_sample(input int style);
        logic [SAMPLE_W-1:0] pats [4];
        pats = '{16'hAAAA, 16'h5555, 16'h0001, 16'h8000};
        case (style)
            STYLE_MAX:     return '1;
            STYLE_ZERO:    return '0;
            STYLE_PATTERN: return pats[$urandom_range(0, 3)];
            default:       return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Offer one sample transaction in bursts with random gaps, hold until taken
    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic last);
        if (burst_left == 0)
        begin
            src_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 30);
        end
        burst_left--;
        src_data  <= cwa_in_t'{sample: s, is_last: last};
        src_valid <= 1'b1;
        do @(posedge clk); while (src_stall);
        items_sent++;
    endtask

    // Send a run of samples, optionally closing the stream on the final one
    task automatic send_stream(input int len, input int style, input logic close);
        for (int i = 0; i < len; i++)
            send_sample(pick_sample(style), close && (i == len - 1));
    endtask

    // Drop valid, wait for every owed average, then let the block go idle
    task automatic settle();
        src_valid <= 1'b0;
        @(negedge clk);
        while (owed_count != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the radius register; only called while the block is idle
    task automatic write_radius(input logic [RADIUS_W-1:0] r);
        cfg_data  <= r;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: stall on its own pattern, plus one long hold-off on request
    initial
    begin
        int run_left;
        int hold_left;
        int stall_pct;
        logic held;
        run_left  = 0;
        hold_left = 0;
        stall_pct = 0;
        held      = 1'b0;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    case ($urandom_range(0, 4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 20;
                        3:       stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                    run_left = $urandom_range(10, 80);
                end
                run_left--;
                res_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Watchdog: end the run when nothing has been accepted for too long
    always @(posedge clk)
    begin
        if (!rst_n || (src_valid && !src_stall) || (res_valid && !res_stall)
                || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("** centered_window_average: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Stimulus and verdict
    initial
    begin
        int r;
        int phase_start;
        int phase_len;
        int sel;
        rst_n       <= 1'b0;
        src_valid   <= 1'b0;
        src_data    <= '0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        hold_req    <= 1'b0;
        items_sent  = 0;
        burst_left  = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Radius zero: each sample is its own average, extremes of the sample
        write_radius(0);
        send_sample('0, 1'b0);
        send_sample('1, 1'b0);
        send_sample(16'hAAAA, 1'b0);
        send_sample(16'h5555, 1'b1);
        settle();

        // Radius one: a one-sample stream, then a short full stream
        write_radius(1);
        send_sample('1, 1'b1);
        send_stream(2, STYLE_MAX, 1'b0);
        send_sample(16'h0001, 1'b1);
        settle();

        // Radius two: a stream left open, which the next radius write restarts
        write_radius(2);
        send_stream(3, STYLE_RANDOM, 1'b0);
        settle();

        // Largest radius with a stream far shorter than the window
        write_radius(31);
        send_stream(10, STYLE_ZERO, 1'b1);
        settle();

        // Exactly one full window
        write_radius(2);
        send_stream(5, STYLE_PATTERN, 1'b1);
        settle();

        // Largest radius with full windows of the largest samples
        write_radius(31);
        send_stream(70, STYLE_MAX, 1'b1);
        settle();

        // Long receiver hold-off while samples keep coming
        write_radius(0);
        hold_req   <= 1'b1;
        burst_left = 1000;
        send_stream(40, STYLE_RANDOM, 1'b1);
        burst_left = 0;
        settle();

        // Random phases: a radius, then streams of random length and content
        while (items_sent < TARGET_ITEMS)
        begin
            sel = $urandom_range(0, 7);
            if (sel == 0)
                r = 0;
            else if (sel == 1)
                r = 31;
            else
                r = $urandom_range(1, 10);
            write_radius(RADIUS_W'(r));
            phase_len   = $urandom_range(15, 60);
            phase_start = items_sent;
            while (items_sent - phase_start < phase_len)
            begin
                sel = $urandom_range(0, 9);
                send_stream($urandom_range(1, 2 * r + 7),
                            (sel < 7) ? STYLE_RANDOM : sel - 6,
                            $urandom_range(0, 7) != 0);
            end
            settle();
        end

        if (mismatches == 0)
            $display("** centered_window_average: PASSED **");
        else
            $display("** centered_window_average: FAILED **");
        $finish;
    end

endmodule
